// File: sv/limit_order_book_matcher_defines.svh
// ----------------------------------------------------------------------------
// limit order book matcher assertion macros
// shared concurrent assertion forms, clocked on i_clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH

// same-cycle implication
`define LOB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LOB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_pkg
// shared types and codes for the limit order book matcher
// ----------------------------------------------------------------------------
package lob_pkg;

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_MODIFY = 2'd1,
        OP_VOLUME = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_DISP,
        ST_LOOK,
        ST_VOL,
        ST_MOD_E,
        ST_MOD_L,
        ST_MOD_FIN,
        ST_SUB_CHK,
        ST_WALK,
        ST_WLVL,
        ST_FRD,
        ST_FEX,
        ST_FNEXT,
        ST_WEND,
        ST_REST_T,
        ST_REST_U,
        ST_UNL_P,
        ST_UNL_P2,
        ST_UNL_N,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  ord_num;
        logic        side;
        logic [9:0]  price;
        logic [15:0] quantity;
    } t_req;

    typedef struct packed {
        logic [10:0] match_count;
        logic [25:0] level_volume;
        logic        found;
        logic        found_side;
        logic [9:0]  found_price;
        logic [15:0] found_quantity;
    } t_res;

endpackage

// File: sv/lob_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob channel interfaces
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface lob_req_if import lob_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lob_res_if import lob_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/limit_order_book_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit order book matcher
// price-indexed order book with fifo matching, run by a small sequencer
// over one order memory and one level memory
// ----------------------------------------------------------------------------
// channel   dir  payload  transfer
// i_req     in   t_req    valid & ready, one operation
// o_res     out  t_res    valid & ready, one result per operation
//
// a modify to quantity zero unlinks the order. a submit that walks visits the
// opposite side's price levels from the best one toward its limit, fills
// resting orders in fifo order, unlinks each order that a fill empties, and
// rests any remainder at its own price.
// after reset a clearing pass over both memories runs with i_req.ready low.
// one result register: the next operation is taken while a result waits,
// and the sequencer holds in its done step until that register is free.
// ----------------------------------------------------------------------------
`include "limit_order_book_matcher_defines.svh"

module limit_order_book_matcher import lob_pkg::*; #(
    parameter int PRICE_LEVELS = 1024,
    parameter int MAX_ORDERS   = 1024,
    parameter int QTY_BITS     = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lob_req_if.sink          i_req,
    lob_res_if.source        o_res
);

    localparam int AW    = $clog2(MAX_ORDERS);
    localparam int IDW   = $clog2(MAX_ORDERS + 1);
    localparam int PAW   = $clog2(PRICE_LEVELS);
    localparam int PW    = $clog2(PRICE_LEVELS + 1);
    localparam int LAW   = $clog2(2 * PRICE_LEVELS);
    localparam int TOTW  = QTY_BITS + IDW;
    localparam int CNTW  = $clog2(MAX_ORDERS + 1);
    localparam int CLR_N = (MAX_ORDERS > 2 * PRICE_LEVELS) ? MAX_ORDERS : 2 * PRICE_LEVELS;
    localparam int CW    = $clog2(CLR_N);
    localparam logic [IDW-1:0] NIL = IDW'(MAX_ORDERS);

    typedef struct packed {
        logic                live;
        logic                side;
        logic [PAW-1:0]      price;
        logic [QTY_BITS-1:0] qty;
        logic [IDW-1:0]      nxt;
        logic [IDW-1:0]      prv;
    } t_ent;

    typedef struct packed {
        logic [IDW-1:0]  head;
        logic [IDW-1:0]  tail;
        logic [TOTW-1:0] total;
    } t_lvl;

    function automatic logic [LAW-1:0] lvl_idx(input logic s, input logic [PAW-1:0] p);
        lvl_idx = s ? LAW'(PRICE_LEVELS) + LAW'(p) : LAW'(p);
    endfunction

    // memories
    t_ent ent_mem [MAX_ORDERS];
    t_lvl lvl_mem [2*PRICE_LEVELS];
    t_ent ent_rd, ent_wd;
    t_lvl lvl_rd, lvl_wd;
    logic ent_we, lvl_we;
    logic [AW-1:0]  ent_wa, ent_ra;
    logic [LAW-1:0] lvl_wa, lvl_ra;

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_wa] <= ent_wd;
        end
        ent_rd <= ent_mem[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            lvl_mem[lvl_wa] <= lvl_wd;
        end
        lvl_rd <= lvl_mem[lvl_ra];
    end

    // sequencer state
    t_state r_state, n_state, r_ret, n_ret;
    logic [CW-1:0]       r_clr, n_clr;
    logic [PW-1:0]       r_bbid, n_bbid, r_bask, n_bask;
    logic                r_ov, n_ov;
    t_res                r_out, n_out;
    t_res                r_res, n_res;
    t_op                 r_op, n_op;
    logic [AW-1:0]       r_id, n_id;
    logic                r_idok, n_idok, r_pok, n_pok;
    logic                r_side, n_side;
    logic [PAW-1:0]      r_price, n_price;
    logic [QTY_BITS-1:0] r_rem, n_rem;
    logic [CNTW-1:0]     r_count, n_count;
    logic [PW:0]         r_p, n_p;
    logic [IDW-1:0]      r_cur, n_cur;
    logic [LAW-1:0]      r_li, n_li;
    t_ent                r_ent, n_ent;
    t_lvl                r_lvl, n_lvl;

    logic                walk_go;
    logic [PW:0]         p_step;
    logic [QTY_BITS-1:0] trade;

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_clr   = r_clr;
        n_bbid  = r_bbid;
        n_bask  = r_bask;
        n_ov    = r_ov;
        n_out   = r_out;
        n_res   = r_res;
        n_op    = r_op;
        n_id    = r_id;
        n_idok  = r_idok;
        n_pok   = r_pok;
        n_side  = r_side;
        n_price = r_price;
        n_rem   = r_rem;
        n_count = r_count;
        n_p     = r_p;
        n_cur   = r_cur;
        n_li    = r_li;
        n_ent   = r_ent;
        n_lvl   = r_lvl;
        ent_we  = 1'b0;
        ent_wa  = AW'(r_cur);
        ent_wd  = r_ent;
        ent_ra  = AW'(r_cur);
        lvl_we  = 1'b0;
        lvl_wa  = r_li;
        lvl_wd  = r_lvl;
        lvl_ra  = r_li;

        walk_go = (r_rem != '0) && (r_side ? ($signed(r_p) >= $signed((PW+1)'(r_price)))
                                           : ($signed(r_p) <= $signed((PW+1)'(r_price))));
        p_step  = r_side ? r_p - (PW+1)'(1) : r_p + (PW+1)'(1);
        trade   = (ent_rd.qty < r_rem) ? ent_rd.qty : r_rem;

        if (o_res.valid && o_res.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_CLR: begin
                ent_we       = (32'(r_clr) < 32'(MAX_ORDERS));
                ent_wa       = AW'(r_clr);
                ent_wd       = '0;
                lvl_we       = (32'(r_clr) < 32'(2 * PRICE_LEVELS));
                lvl_wa       = LAW'(r_clr);
                lvl_wd.head  = NIL;
                lvl_wd.tail  = NIL;
                lvl_wd.total = '0;
                if (r_clr == CW'(CLR_N - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + CW'(1);
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_op    = t_op'(i_req.data.op);
                    n_id    = AW'(i_req.data.ord_num);
                    n_idok  = (32'(i_req.data.ord_num) < 32'(MAX_ORDERS));
                    n_pok   = (32'(i_req.data.price) < 32'(PRICE_LEVELS));
                    n_side  = i_req.data.side;
                    n_price = PAW'(i_req.data.price);
                    n_rem   = QTY_BITS'(i_req.data.quantity);
                    n_res   = '0;
                    n_count = '0;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                n_cur   = IDW'(r_id);
                ent_ra  = r_id;
                lvl_ra  = lvl_idx(r_side, r_price);
                n_state = ST_DONE;
                case (r_op)
                    OP_SUBMIT: if (r_idok && r_pok) n_state = ST_SUB_CHK;
                    OP_MODIFY: if (r_idok) n_state = ST_MOD_E;
                    OP_VOLUME: if (r_pok) n_state = ST_VOL;
                    OP_LOOKUP: if (r_idok) n_state = ST_LOOK;
                    default:   n_state = ST_DONE;
                endcase
            end
            ST_LOOK: begin
                if (ent_rd.live) begin
                    n_res.found          = 1'b1;
                    n_res.found_side     = ent_rd.side;
                    n_res.found_price    = 10'(ent_rd.price);
                    n_res.found_quantity = 16'(ent_rd.qty);
                end
                n_state = ST_DONE;
            end
            ST_VOL: begin
                n_res.level_volume = 26'(lvl_rd.total);
                n_state            = ST_DONE;
            end
            ST_MOD_E: begin
                if (!ent_rd.live) begin
                    n_state = ST_DONE;
                end else begin
                    n_ent   = ent_rd;
                    n_li    = lvl_idx(ent_rd.side, ent_rd.price);
                    lvl_ra  = lvl_idx(ent_rd.side, ent_rd.price);
                    n_state = ST_MOD_L;
                end
            end
            ST_MOD_L: begin
                n_lvl       = lvl_rd;
                n_lvl.total = lvl_rd.total - TOTW'(r_ent.qty) + TOTW'(r_rem);
                n_ent.qty   = r_rem;
                if (r_rem != '0) begin
                    ent_we  = 1'b1;
                    ent_wd  = n_ent;
                    lvl_we  = 1'b1;
                    lvl_wd  = n_lvl;
                    n_state = ST_DONE;
                end else begin
                    n_ret   = ST_MOD_FIN;
                    n_state = ST_UNL_P;
                end
            end
            ST_MOD_FIN: begin
                lvl_we  = 1'b1;
                n_state = ST_DONE;
            end
            ST_SUB_CHK: begin
                if (ent_rd.live || r_rem == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_p     = r_side ? {1'b0, r_bbid} : {1'b0, r_bask};
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                n_li    = lvl_idx(~r_side, PAW'(r_p));
                lvl_ra  = lvl_idx(~r_side, PAW'(r_p));
                n_state = walk_go ? ST_WLVL : ST_WEND;
            end
            ST_WLVL: begin
                if (lvl_rd.total == '0) begin
                    n_p     = p_step;
                    n_state = ST_WALK;
                end else begin
                    n_lvl   = lvl_rd;
                    n_cur   = lvl_rd.head;
                    n_state = ST_FRD;
                end
            end
            ST_FRD: begin
                n_state = ST_FEX;
            end
            ST_FEX: begin
                n_ent       = ent_rd;
                n_ent.qty   = ent_rd.qty - trade;
                n_rem       = r_rem - trade;
                n_lvl.total = r_lvl.total - TOTW'(trade);
                n_count     = r_count + CNTW'(1);
                if (ent_rd.qty == trade) begin
                    n_ret   = ST_FNEXT;
                    n_state = ST_UNL_P;
                end else begin
                    ent_we  = 1'b1;
                    ent_wd  = n_ent;
                    n_state = ST_FNEXT;
                end
            end
            ST_FNEXT: begin
                n_cur = r_ent.nxt;
                if (r_ent.nxt != NIL && r_rem != '0) begin
                    n_state = ST_FRD;
                end else begin
                    lvl_we = 1'b1;
                    if (r_lvl.total == '0) begin
                        n_p = p_step;
                    end
                    n_state = ST_WALK;
                end
            end
            ST_WEND: begin
                n_res.match_count = 11'(r_count);
                if (r_side) begin
                    n_bbid = r_p[PW] ? '0 : PW'(r_p);
                    if (r_rem != '0 && PW'(r_price) < r_bask) n_bask = PW'(r_price);
                end else begin
                    n_bask = PW'(r_p);
                    if (r_rem != '0 && PW'(r_price) > r_bbid) n_bbid = PW'(r_price);
                end
                n_li    = lvl_idx(r_side, r_price);
                lvl_ra  = lvl_idx(r_side, r_price);
                n_state = (r_rem != '0) ? ST_REST_T : ST_DONE;
            end
            ST_REST_T: begin
                ent_we       = 1'b1;
                ent_wa       = r_id;
                ent_wd.live  = 1'b1;
                ent_wd.side  = r_side;
                ent_wd.price = r_price;
                ent_wd.qty   = r_rem;
                ent_wd.nxt   = NIL;
                ent_wd.prv   = lvl_rd.tail;
                lvl_we       = 1'b1;
                lvl_wd.head  = (lvl_rd.tail == NIL) ? IDW'(r_id) : lvl_rd.head;
                lvl_wd.tail  = IDW'(r_id);
                lvl_wd.total = lvl_rd.total + TOTW'(r_rem);
                n_cur        = lvl_rd.tail;
                ent_ra       = AW'(lvl_rd.tail);
                n_state      = (lvl_rd.tail == NIL) ? ST_DONE : ST_REST_U;
            end
            ST_REST_U: begin
                // link the old tail forward to the new order
                ent_we     = 1'b1;
                ent_wd     = ent_rd;
                ent_wd.nxt = IDW'(r_id);
                n_state    = ST_DONE;
            end
            ST_UNL_P: begin
                ent_we      = 1'b1;
                ent_wd.live = 1'b0;
                if (r_ent.prv == NIL) n_lvl.head = r_ent.nxt;
                if (r_ent.nxt == NIL) n_lvl.tail = r_ent.prv;
                ent_ra      = AW'(r_ent.prv);
                n_state     = ST_UNL_P2;
            end
            ST_UNL_P2: begin
                ent_we     = (r_ent.prv != NIL);
                ent_wa     = AW'(r_ent.prv);
                ent_wd     = ent_rd;
                ent_wd.nxt = r_ent.nxt;
                ent_ra     = AW'(r_ent.nxt);
                n_state    = ST_UNL_N;
            end
            ST_UNL_N: begin
                ent_we     = (r_ent.nxt != NIL);
                ent_wa     = AW'(r_ent.nxt);
                ent_wd     = ent_rd;
                ent_wd.prv = r_ent.prv;
                n_state    = r_ret;
            end
            ST_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_bbid  <= '0;
            r_bask  <= PW'(PRICE_LEVELS);
            r_ov    <= 1'b0;
            r_ret   <= ST_DONE;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_bbid  <= n_bbid;
            r_bask  <= n_bask;
            r_ov    <= n_ov;
            r_ret   <= n_ret;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_res   <= n_res;
        r_op    <= n_op;
        r_id    <= n_id;
        r_idok  <= n_idok;
        r_pok   <= n_pok;
        r_side  <= n_side;
        r_price <= n_price;
        r_rem   <= n_rem;
        r_count <= n_count;
        r_p     <= n_p;
        r_cur   <= n_cur;
        r_li    <= n_li;
        r_ent   <= n_ent;
        r_lvl   <= n_lvl;
    end

    // checks
    `LOB_ASSERT_NXT(a_done_loads, (r_state == ST_DONE) && (!r_ov || o_res.ready), r_ov && (r_state == ST_IDLE), "result not loaded on done")
    `LOB_ASSERT_NOW(a_no_take_clr, r_state == ST_CLR, !i_req.ready, "request taken during clearing pass")
    `LOB_ASSERT_NXT(a_fill_shrinks, r_state == ST_FEX, r_rem < $past(r_rem), "fill traded nothing")
    `LOB_ASSERT_NOW(a_ask_range, r_state == ST_IDLE, r_bask <= PW'(PRICE_LEVELS), "best ask out of range")
    `LOB_ASSERT_NOW(a_count_range, r_state == ST_WEND, 32'(r_count) <= 32'(MAX_ORDERS), "match count too large")

endmodule
